// ===== design/itc_pkg.sv =====
// Package for the interval timer channel: item and result types, action and
// port codes, and reset constants. Used by itc_core and interval_timer_channel0.
// No dependencies.
`default_nettype none

package itc_pkg;

  // Field widths fixed by the stream format.
  localparam int ACTION_W = 2;
  localparam int PORT_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int TICK_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int RELOAD_W = 17;

  // Default width of the tick amount that the counter actually sees.
  localparam int AMOUNT_WIDTH_DEFAULT = 16;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

  // Port offsets.
  localparam logic [PORT_W-1:0] PORT_COUNTER = 16'd0;
  localparam logic [PORT_W-1:0] PORT_MODE_A  = 16'd2;
  localparam logic [PORT_W-1:0] PORT_MODE_B  = 16'd3;

  // Reset value of both the reload and the counter.
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 17'd100000;

  // One input beat, unpacked.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PORT_W-1:0]   port;
    logic [BYTE_W-1:0]   write_byte;
    logic [TICK_W-1:0]   tick_amount;
  } item_t;

  // One result beat, unpacked.
  typedef struct packed {
    logic              port_error;
    logic              irq_pulse;
    logic [BYTE_W-1:0] read_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== design/interval_timer_channel0.sv =====
// Top level of the interval timer channel: input register, core and result
// register on stream ports. Depends on itc_pkg and itc_core.
`default_nettype none

// Each input beat is a tick, a port read or a port write, and yields exactly
// one result beat. The block takes one beat per clock cycle when the output
// side keeps up. An accepted beat is captured in the input register and then
// moves into the result register, which presents it; the counter update, a
// subtract, a sign test and a reload add, is combinational logic between
// these two registers. When the output side stalls, the input side stops
// accepting once a beat waits in the input register. After reset the counter
// and reload both hold 100000 and the low byte comes next.
module interval_timer_channel0 #(
  parameter int AMOUNT_WIDTH = itc_pkg::AMOUNT_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // port[15:0], write_byte[23:16], tick_amount[39:24]
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // read_byte[7:0], irq_pulse[8], port_error[9], zero
);
  import itc_pkg::*;

  logic    stage_valid;
  item_t   stage_item;
  logic    advance;
  result_t core_result;

  // An item moves to the result register when that register is free or drains.
  assign advance  = stage_valid && (!m_tvalid || m_tready);
  assign s_tready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stage_item.action      <= s_tuser;
      stage_item.port        <= s_tdata[15:0];
      stage_item.write_byte  <= s_tdata[23:16];
      stage_item.tick_amount <= s_tdata[39:24];
    end
  end

  itc_core #(
    .AMOUNT_WIDTH(AMOUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage_item),
    .result (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'd0, core_result.port_error, core_result.irq_pulse, core_result.read_byte};
    end
  end

`ifndef SYNTH
  // A beat held in the input register stays there unchanged until it moves on.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_item))
    else $error("input register lost or changed a waiting beat");

  // An interrupt and a port error never come from the same beat.
  a_irq_err_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
    else $error("irq_pulse and port_error both set");

  // A tick that raised the interrupt returns no read data.
  a_irq_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
    else $error("interrupt beat carries read data");

  // Every committed item lands in the result register in the next cycle.
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("committed item produced no result beat");
`endif

endmodule

`default_nettype wire

// ===== design/itc_core.sv =====
// Timer channel core: byte toggle, reload and down counter registers, and the
// combinational update and result logic for one item. Depends on itc_pkg.
`default_nettype none

module itc_core #(
  parameter int AMOUNT_WIDTH = itc_pkg::AMOUNT_WIDTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,    // commit the item this cycle
  input  wire itc_pkg::item_t  item,
  output itc_pkg::result_t     result
);
  import itc_pkg::*;

  localparam logic [COUNT_W-1:0] AmountMask = COUNT_W'((64'd1 << AMOUNT_WIDTH) - 64'd1);

  logic                byte_toggle;
  logic [RELOAD_W-1:0] reload_value;
  logic [COUNT_W-1:0]  count_value;

  logic                byte_toggle_next;
  logic [RELOAD_W-1:0] reload_value_next;
  logic [COUNT_W-1:0]  count_value_next;

  logic [COUNT_W-1:0]  amount_half;
  logic [COUNT_W-1:0]  count_dec;
  logic                is_counter_port;
  logic                is_mode_port;

  assign amount_half     = (COUNT_W'(item.tick_amount) & AmountMask) >> 1;
  assign count_dec       = count_value - amount_half;
  assign is_counter_port = (item.port == PORT_COUNTER);
  assign is_mode_port    = (item.port == PORT_MODE_A) || (item.port == PORT_MODE_B);

  // Next state and result for the item at the core's input.
  always_comb begin
    byte_toggle_next  = byte_toggle;
    reload_value_next = reload_value;
    count_value_next  = count_value;
    result            = '0;
    case (item.action)
      ACT_TICK: begin
        if (!byte_toggle) begin
          count_value_next = count_dec;
          // Underflow below zero raises the interrupt and reloads once.
          if (count_dec[COUNT_W-1]) begin
            result.irq_pulse = 1'b1;
            count_value_next = count_dec + COUNT_W'(reload_value);
          end
        end
      end
      ACT_READ: begin
        if (is_counter_port) begin
          byte_toggle_next = ~byte_toggle;
          result.read_byte = byte_toggle ? count_value[15:8] : count_value[7:0];
        end else begin
          result.port_error = 1'b1;
        end
      end
      ACT_WRITE: begin
        if (is_counter_port) begin
          byte_toggle_next = ~byte_toggle;
          if (!byte_toggle) begin
            reload_value_next = {1'b0, reload_value[15:8], item.write_byte};
          end else begin
            reload_value_next = {1'b0, item.write_byte, reload_value[7:0]};
            count_value_next  = {16'd0, item.write_byte, reload_value[7:0]};
          end
        end else if (!is_mode_port) begin
          result.port_error = 1'b1;
        end
      end
      default: begin
        // Undefined action: no effect, all-zero result.
      end
    endcase
  end

  // Timer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_toggle  <= 1'b0;
      reload_value <= RELOAD_RESET;
      count_value  <= COUNT_W'(RELOAD_RESET);
    end else if (step) begin
      byte_toggle  <= byte_toggle_next;
      reload_value <= reload_value_next;
      count_value  <= count_value_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/interval_timer_channel0_tb.sv =====
// Testbench for interval_timer_channel0: drives tick, read and write beats
// and checks every result beat against a cycle-free model of the channel.
// Depends on itc_pkg and the interval_timer_channel0 RTL.
`timescale 1ns / 1ps

module interval_timer_channel0_tb;
  import itc_pkg::*;

  // Action code 3 does nothing and returns an all-zero result.
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  // Tick amount bits that reach the counter.
  localparam logic [31:0] AMOUNT_MASK = (32'd1 << AMOUNT_WIDTH_DEFAULT) - 32'd1;

  localparam int RANDOM_BEATS = 750;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Expected results of the timer channel, computed beat by beat.
  class timer_scoreboard;
    logic             high_next;
    logic [RELOAD_W-1:0] reload;
    logic [COUNT_W-1:0]  counter;
    result_t          expected[$];
    int               mismatches;

    function new();
      high_next  = 1'b0;
      reload     = RELOAD_RESET;
      counter    = {{(COUNT_W-RELOAD_W){1'b0}}, RELOAD_RESET};
      mismatches = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // Advances the timer state by one beat and returns its result.
    function result_t step_timer(item_t beat);
      result_t     res;
      logic [31:0] half;
      res = '0;
      case (beat.action)
        ACT_TICK: begin
          // A half-done byte pair freezes the counter.
          if (!high_next) begin
            half = ({16'd0, beat.tick_amount} & AMOUNT_MASK) >> 1;
            counter = counter - half;
            if (counter[COUNT_W-1]) begin
              res.irq_pulse = 1'b1;
              counter = counter + {{(COUNT_W-RELOAD_W){1'b0}}, reload};
            end
          end
        end
        ACT_READ: begin
          if (beat.port == PORT_COUNTER) begin
            res.read_byte = high_next ? counter[15:8] : counter[7:0];
            high_next = !high_next;
          end else begin
            res.port_error = 1'b1;
          end
        end
        ACT_WRITE: begin
          if (beat.port == PORT_COUNTER) begin
            // The high byte completes the reload and loads the counter.
            if (!high_next) begin
              reload = {1'b0, reload[15:8], beat.write_byte};
            end else begin
              reload = {1'b0, beat.write_byte, reload[7:0]};
              counter = {{(COUNT_W-RELOAD_W){1'b0}}, reload};
            end
            high_next = !high_next;
          end else if (beat.port != PORT_MODE_A && beat.port != PORT_MODE_B) begin
            res.port_error = 1'b1;
          end
        end
        default: begin
        end
      endcase
      return res;
    endfunction

    function void note_beat(item_t beat);
      expected.push_back(step_timer(beat));
    endfunction

    function void check_beat(logic [15:0] word);
      result_t want;
      if (expected.size() == 0) begin
        $display("%0t: result beat %h with no result expected", $time, word);
        mismatches++;
        return;
      end
      want = expected.pop_front();
      if (word[7:0] !== want.read_byte) begin
        $display("%0t: read_byte expected %h, got %h", $time, want.read_byte, word[7:0]);
        mismatches++;
      end
      if (word[8] !== want.irq_pulse) begin
        $display("%0t: irq_pulse expected %b, got %b", $time, want.irq_pulse, word[8]);
        mismatches++;
      end
      if (word[9] !== want.port_error) begin
        $display("%0t: port_error expected %b, got %b", $time, want.port_error, word[9]);
        mismatches++;
      end
      if (word[15:10] !== 6'd0) begin
        $display("%0t: padding expected 00, got %h", $time, word[15:10]);
        mismatches++;
      end
    endfunction
  endclass

  typedef enum {RX_STREAM, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // port[15:0], write_byte[23:16], tick_amount[39:24]
  logic [1:0]  s_tuser = '0;   // action[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // read_byte[7:0], irq_pulse[8], port_error[9], zero

  timer_scoreboard sb = new();

  int       beats_sent = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  rx_mode_e rx_mode = RX_STREAM;
  int       mode_left = 0;
  int       stall_left = 0;
  int       phase = 0;

  interval_timer_channel0 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Record accepted input beats and check accepted result beats.
  always @(posedge clk) begin
    item_t beat;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        beat.action      = s_tuser;
        beat.port        = s_tdata[15:0];
        beat.write_byte  = s_tdata[23:16];
        beat.tick_amount = s_tdata[39:24];
        sb.note_beat(beat);
      end
      if (m_tvalid && m_tready) begin
        sb.check_beat(m_tdata);
      end
    end
  end

  // Receiver backpressure: the stall style is redrawn each time its current run ends.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(64, 400);
    end
    mode_left--;
    phase++;
    case (rx_mode)
      RX_STREAM: m_tready <= 1'b1;
      RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 6);
      RX_PERIODIC: m_tready <= ((phase % 7) < 4);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 24);
        end
      end
    endcase
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sends one beat; the sender runs in bursts with random gaps between them.
  task send_beat(input logic [1:0] act, input logic [15:0] prt, input logic [7:0] wbyte,
                 input logic [15:0] amount);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {amount, wbyte, prt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Holds the sender off until every expected result has been seen.
  task wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function logic [15:0] draw_amount();
    case ($urandom_range(0, 2))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  function logic [15:0] draw_bad_write_port();
    logic [15:0] prt;
    prt = 16'($urandom);
    while (prt == PORT_COUNTER || prt == PORT_MODE_A || prt == PORT_MODE_B) begin
      prt = 16'($urandom);
    end
    return prt;
  endfunction

  initial begin
    int pick;
    int reps;
    logic pressure_done;
    pressure_done = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset values, byte toggle, underflow and bad ports.
    send_beat(ACT_READ, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_READ, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_TICK, 16'h0000, 8'h00, 16'hFFFF);
    send_beat(ACT_TICK, 16'h0000, 8'h00, 16'h0000);
    send_beat(ACT_TICK, 16'h0000, 8'h00, 16'h0001);
    // Zero reload: an underflow leaves the counter negative.
    send_beat(ACT_WRITE, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_WRITE, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_TICK, 16'h0000, 8'h00, 16'h0002);
    send_beat(ACT_TICK, 16'h0000, 8'h00, 16'h0003);
    send_beat(ACT_READ, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_READ, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_WRITE, PORT_COUNTER, 8'hFF, 16'h0000);
    send_beat(ACT_WRITE, PORT_COUNTER, 8'hFF, 16'h0000);
    // Ticks between the two bytes of a pair are skipped.
    send_beat(ACT_READ, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_TICK, 16'h0000, 8'h00, 16'hFFFF);
    send_beat(ACT_READ, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_WRITE, PORT_COUNTER, 8'h34, 16'h0000);
    send_beat(ACT_TICK, 16'h0000, 8'h00, 16'hFFFF);
    send_beat(ACT_WRITE, PORT_COUNTER, 8'h12, 16'h0000);
    // Ignored ports, unknown ports and the empty action.
    send_beat(ACT_WRITE, PORT_MODE_A, 8'hAA, 16'h0000);
    send_beat(ACT_WRITE, PORT_MODE_B, 8'h55, 16'h0000);
    send_beat(ACT_WRITE, 16'h0001, 8'h77, 16'h0000);
    send_beat(ACT_READ, PORT_MODE_A, 8'h00, 16'h0000);
    send_beat(ACT_READ, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_beat(ACT_WRITE, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_beat(ACT_NONE, 16'hFFFF, 8'hFF, 16'hFFFF);
    // A read and a write share the toggle; then underflow with a small reload.
    send_beat(ACT_READ, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_WRITE, PORT_COUNTER, 8'h00, 16'h0000);
    send_beat(ACT_TICK, 16'h0000, 8'h00, 16'h006A);
    wait_drained();

    // Random part: mostly well-formed byte pairs and ticks, some noise.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (!pressure_done && beats_sent >= RANDOM_BEATS / 2) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        reps = $urandom_range(1, 6);
        repeat (reps) send_beat(ACT_TICK, 16'($urandom), 8'($urandom), draw_amount());
      end else if (pick < 58) begin
        repeat (2) send_beat(ACT_READ, PORT_COUNTER, 8'($urandom), 16'($urandom));
      end else if (pick < 73) begin
        send_beat(ACT_WRITE, PORT_COUNTER, 8'($urandom), 16'($urandom));
        send_beat(ACT_WRITE, PORT_COUNTER,
                  ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom), 16'($urandom));
      end else if (pick < 80) begin
        // Lone byte access: leaves the pair half done.
        if ($urandom_range(0, 1) == 0) begin
          send_beat(ACT_READ, PORT_COUNTER, 8'($urandom), 16'($urandom));
        end else begin
          send_beat(ACT_WRITE, PORT_COUNTER, 8'($urandom), 16'($urandom));
        end
        send_beat(ACT_TICK, 16'($urandom), 8'($urandom), draw_amount());
      end else if (pick < 86) begin
        send_beat(ACT_WRITE, ($urandom_range(0, 1) == 0) ? PORT_MODE_A : PORT_MODE_B,
                  8'($urandom), 16'($urandom));
      end else if (pick < 94) begin
        if ($urandom_range(0, 1) == 0) begin
          send_beat(ACT_READ, 16'($urandom_range(1, 65535)), 8'($urandom), 16'($urandom));
        end else begin
          send_beat(ACT_WRITE, draw_bad_write_port(), 8'($urandom), 16'($urandom));
        end
      end else begin
        send_beat(ACT_NONE, 16'($urandom), 8'($urandom), 16'($urandom));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
